// ===== design/prg_pkg.sv =====
// ----------------------------------------------------------------------------
// prg_pkg: shared types and constants for the primary ray generator
// Field widths, register indexes, pipeline sizes and the config/tag structs.
// ----------------------------------------------------------------------------
package prg_pkg;

	localparam int COORD_BITS = 12;             // bits of width, height, row, col used
	localparam int DIM_W      = 12;             // pixel and size field width
	localparam int COMP_W     = 21;             // Q10.10 component
	localparam int VEC_W      = 3 * COMP_W;     // packed xyz register
	localparam int DIR_W      = 16;             // Q1.15 direction
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EYE          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y       = 3'd5;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

	localparam int PROD_W = 2 * COORD_BITS;      // pixel-count products
	localparam int N_W    = PROD_W + COMP_W + 3; // signed unnormalized direction
	localparam int MAG_W  = N_W - 1;
	localparam int NRM_W  = 31;                  // magnitude after common shift
	localparam int SH_W   = $clog2(MAG_W - NRM_W + 2);
	localparam int SQ_W   = 2 * NRM_W;
	localparam int SUM_W  = 64;
	localparam int QUO_W  = 33;                  // n^2 * 2^32 / S
	localparam int ROOT_W = 17;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [VEC_W-1:0] eye;
		logic [VEC_W-1:0] corner;
		logic [VEC_W-1:0] span_x;
		logic [VEC_W-1:0] span_y;
	} prg_cfg_t;

	typedef struct packed {
		logic       oor;    // pixel outside image
		logic       szero;  // direction vector is zero
		logic [2:0] neg;    // component signs
	} prg_tag_t;

	function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] v,
			input int k);
		return v[k*COMP_W +: COMP_W];
	endfunction

endpackage

// ===== design/prg_pixel_if.sv =====
// ----------------------------------------------------------------------------
// prg_pixel_if / prg_ray_if: valid/ready channels of the ray generator
// Pixel words in, ray words out.
// ----------------------------------------------------------------------------
interface prg_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [prg_pkg::DIM_W-1:0]   pixel_row;
	logic [prg_pkg::DIM_W-1:0]   pixel_col;
	modport source(output valid, pixel_row, pixel_col, input ready);
	modport sink(input valid, pixel_row, pixel_col, output ready);
endinterface

interface prg_ray_if;
	logic                              valid;
	logic                              ready;
	logic signed [prg_pkg::COMP_W-1:0] origin_x;
	logic signed [prg_pkg::COMP_W-1:0] origin_y;
	logic signed [prg_pkg::COMP_W-1:0] origin_z;
	logic signed [prg_pkg::DIR_W-1:0]  dir_x;
	logic signed [prg_pkg::DIR_W-1:0]  dir_y;
	logic signed [prg_pkg::DIR_W-1:0]  dir_z;
	logic                              out_of_range;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		out_of_range, input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		out_of_range, output ready);
endinterface

// ===== design/prg_front.sv =====
// ----------------------------------------------------------------------------
// prg_front: direction vector, common normalize shift and sum of squares
// Seven stages: bound check and pixel products, component products, sum,
// shift search, shift, squares, sum of squares.
// ----------------------------------------------------------------------------
module prg_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [prg_pkg::DIM_W-1:0]          pixel_row,
	input  logic [prg_pkg::DIM_W-1:0]          pixel_col,
	input  prg_pkg::prg_cfg_t                  cfg,
	output logic                               out_valid,
	output logic [prg_pkg::SQ_W-1:0]           n2 [3],
	output logic [prg_pkg::SUM_W-1:0]          ssum,
	output prg_pkg::prg_tag_t                  tag
);
	import prg_pkg::*;

	logic [7:1] vld_s;

	logic [COORD_BITS-1:0] row, col, w, h;
	logic                  oor;

	logic [PROD_W-1:0]        wh_s1, ch_s1, rw_s1;
	logic                     oor_s1, oor_s2;
	logic signed [COMP_W:0]   dif [3];
	logic signed [N_W-1:0]    pa_s2 [3], pb_s2 [3], pc_s2 [3];
	logic signed [N_W-1:0]    nsum [3];
	logic signed [N_W-1:0]    nabs [3];
	logic [MAG_W-1:0]         mag_s3 [3], mag_s4 [3];
	logic [MAG_W-1:0]         orv;
	logic [SH_W-1:0]          sh, sh_s4;
	logic [NRM_W-1:0]         nrm_s5 [3];
	logic [SQ_W-1:0]          sq_s6 [3], sq_s7 [3];
	logic [SUM_W-1:0]         ssum_s7;
	prg_tag_t                 tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;

	always_comb begin
		row = pixel_row[COORD_BITS-1:0];
		col = pixel_col[COORD_BITS-1:0];
		w   = cfg.width[COORD_BITS-1:0];
		h   = cfg.height[COORD_BITS-1:0];
		oor = (w == '0) || (h == '0) || (row >= h) || (col >= w);
		for (int k = 0; k < 3; k++) begin
			dif[k] = (COMP_W+1)'(comp_of(cfg.corner, k))
				- (COMP_W+1)'(comp_of(cfg.eye, k));
			nsum[k] = pa_s2[k] + pb_s2[k] + pc_s2[k];
			nabs[k] = nsum[k][N_W-1] ? -nsum[k] : nsum[k];
		end
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2];
		sh  = '0;
		for (int i = NRM_W; i < MAG_W; i++)
			if (orv[i]) sh = SH_W'(i - NRM_W + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wh_s1  <= PROD_W'(w) * PROD_W'(h);
			ch_s1  <= PROD_W'(col) * PROD_W'(h);
			rw_s1  <= PROD_W'(h - row) * PROD_W'(w);
			oor_s1 <= oor;
			oor_s2 <= oor_s1;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k]  <= dif[k] * $signed({1'b0, wh_s1});
				pb_s2[k]  <= $signed({1'b0, ch_s1}) * comp_of(cfg.span_x, k);
				pc_s2[k]  <= $signed({1'b0, rw_s1}) * comp_of(cfg.span_y, k);
				mag_s3[k] <= nabs[k][MAG_W-1:0];
				tag_s3.neg[k] <= nsum[k][N_W-1];
				mag_s4[k] <= mag_s3[k];
				nrm_s5[k] <= NRM_W'(mag_s4[k] >> sh_s4);
				sq_s6[k]  <= SQ_W'(nrm_s5[k]) * SQ_W'(nrm_s5[k]);
				sq_s7[k]  <= sq_s6[k];
			end
			tag_s3.oor   <= oor_s2;
			tag_s3.szero <= 1'b0;
			sh_s4        <= sh;
			tag_s4       <= tag_s3;
			tag_s5       <= tag_s4;
			tag_s6.oor   <= tag_s5.oor;
			tag_s6.neg   <= tag_s5.neg;
			tag_s6.szero <= (nrm_s5[0] == '0) && (nrm_s5[1] == '0) && (nrm_s5[2] == '0);
			tag_s7       <= tag_s6;
			ssum_s7      <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
		end
	end

	assign out_valid = vld_s[7];
	assign n2        = sq_s7;
	assign ssum      = ssum_s7;
	assign tag       = tag_s7;

endmodule

// ===== design/prg_div.sv =====
// ----------------------------------------------------------------------------
// prg_div: pipelined restoring divider, three lanes
// Quotient floor(n^2 * 2^32 / S), one quotient bit per stage.
// ----------------------------------------------------------------------------
module prg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [prg_pkg::SQ_W-1:0]      n2 [3],
	input  logic [prg_pkg::SUM_W-1:0]     ssum,
	input  prg_pkg::prg_tag_t             in_tag,
	output logic                          out_valid,
	output logic [prg_pkg::QUO_W-1:0]     quo [3],
	output prg_pkg::prg_tag_t             out_tag
);
	import prg_pkg::*;

	logic [QUO_W:1]     vld_s;
	logic [SUM_W-1:0]   rem_s [1:QUO_W][3];
	logic [QUO_W-1:0]   quo_s [1:QUO_W][3];
	logic [SUM_W-1:0]   den_s [1:QUO_W];
	prg_tag_t           tag_s [1:QUO_W];

	logic [SUM_W-1:0]   rin [0:QUO_W-1][3];
	logic [QUO_W-1:0]   qin [0:QUO_W-1][3];
	logic [SUM_W-1:0]   din [0:QUO_W-1];
	logic [SUM_W-1:0]   rnx [0:QUO_W-1][3];
	logic [QUO_W-1:0]   qnx [0:QUO_W-1][3];

	always_comb begin
		logic [SUM_W:0] rp;
		logic           bitin;
		logic           ge;
		din[0] = ssum;
		for (int k = 0; k < 3; k++) begin
			rin[0][k] = SUM_W'(n2[k] >> 1);
			qin[0][k] = '0;
		end
		for (int j = 1; j < QUO_W; j++) begin
			din[j] = den_s[j];
			for (int k = 0; k < 3; k++) begin
				rin[j][k] = rem_s[j][k];
				qin[j][k] = quo_s[j][k];
			end
		end
		for (int j = 0; j < QUO_W; j++) begin
			for (int k = 0; k < 3; k++) begin
				// the only nonzero dividend bit below n^2>>1 is n^2[0], shifted in first
				bitin = (j == 0) ? n2[k][0] : 1'b0;
				rp    = {rin[j][k], bitin};
				ge    = rp >= {1'b0, din[j]};
				rnx[j][k] = ge ? SUM_W'(rp - {1'b0, din[j]}) : rp[SUM_W-1:0];
				qnx[j][k] = {qin[j][k][QUO_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QUO_W-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[1] <= ssum;
			tag_s[1] <= in_tag;
			for (int j = 1; j < QUO_W; j++) begin
				den_s[j+1] <= den_s[j];
				tag_s[j+1] <= tag_s[j];
			end
			for (int j = 0; j < QUO_W; j++) begin
				for (int k = 0; k < 3; k++) begin
					rem_s[j+1][k] <= rnx[j][k];
					quo_s[j+1][k] <= qnx[j][k];
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

// ===== design/prg_sqrt.sv =====
// ----------------------------------------------------------------------------
// prg_sqrt: pipelined restoring integer square root, three lanes
// One root bit per stage, two radicand bits consumed per stage.
// ----------------------------------------------------------------------------
module prg_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [prg_pkg::QUO_W-1:0]     rad [3],
	input  prg_pkg::prg_tag_t             in_tag,
	output logic                          out_valid,
	output logic [prg_pkg::ROOT_W-1:0]    root [3],
	output prg_pkg::prg_tag_t             out_tag
);
	import prg_pkg::*;

	logic [ROOT_W:1]    vld_s;
	logic [RAD_W-1:0]   rad_s  [1:ROOT_W][3];
	logic [REM_W-1:0]   rem_s  [1:ROOT_W][3];
	logic [ROOT_W-1:0]  root_s [1:ROOT_W][3];
	prg_tag_t           tag_s  [1:ROOT_W];

	logic [RAD_W-1:0]   ain [0:ROOT_W-1][3];
	logic [REM_W-1:0]   rin [0:ROOT_W-1][3];
	logic [ROOT_W-1:0]  tin [0:ROOT_W-1][3];
	logic [REM_W-1:0]   rnx [0:ROOT_W-1][3];
	logic [ROOT_W-1:0]  tnx [0:ROOT_W-1][3];

	always_comb begin
		logic [REM_W-1:0] rm;
		logic [REM_W-1:0] trial;
		logic             ge;
		for (int k = 0; k < 3; k++) begin
			ain[0][k] = RAD_W'(rad[k]);
			rin[0][k] = '0;
			tin[0][k] = '0;
		end
		for (int j = 1; j < ROOT_W; j++) begin
			for (int k = 0; k < 3; k++) begin
				ain[j][k] = rad_s[j][k];
				rin[j][k] = rem_s[j][k];
				tin[j][k] = root_s[j][k];
			end
		end
		for (int j = 0; j < ROOT_W; j++) begin
			for (int k = 0; k < 3; k++) begin
				rm    = {rin[j][k][REM_W-3:0], ain[j][k][2*(ROOT_W-1-j) +: 2]};
				trial = REM_W'({tin[j][k], 2'b01});
				ge    = rm >= trial;
				rnx[j][k] = ge ? rm - trial : rm;
				tnx[j][k] = {tin[j][k][ROOT_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROOT_W-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[1] <= in_tag;
			for (int j = 1; j < ROOT_W; j++)
				tag_s[j+1] <= tag_s[j];
			for (int j = 0; j < ROOT_W; j++) begin
				for (int k = 0; k < 3; k++) begin
					rad_s[j+1][k]  <= ain[j][k];
					rem_s[j+1][k]  <= rnx[j][k];
					root_s[j+1][k] <= tnx[j][k];
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_tag   = tag_s[ROOT_W];

endmodule

// ===== design/primary_ray_generator.sv =====
// ----------------------------------------------------------------------------
// primary_ray_generator: pinhole camera primary ray per pixel
// Takes one pixel word per cycle and returns one ray word through 7 front
// stages, 33 divider stages, 17 square-root stages and an output register.
// The 33-stage restoring divider that forms n^2*2^32/S sets the latency; the
// throughput is one ray per cycle while the output is taken. Otherwise the
// whole pipeline holds. Write configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module primary_ray_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prg_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [prg_pkg::VEC_W-1:0]         cfg_data,
	prg_pixel_if.sink                         pix,
	prg_ray_if.source                         ray
);
	import prg_pkg::*;

	prg_cfg_t cfg_q;
	logic     en;

	logic              fr_valid;
	logic [SQ_W-1:0]   fr_n2 [3];
	logic [SUM_W-1:0]  fr_ssum;
	prg_tag_t          fr_tag;

	logic              dv_valid;
	logic [QUO_W-1:0]  dv_quo [3];
	prg_tag_t          dv_tag;

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root [3];
	prg_tag_t          sq_tag;

	logic                     out_vld_q;
	logic signed [COMP_W-1:0] org_q [3];
	logic signed [DIR_W-1:0]  dir_q [3];
	logic                     oor_q;

	logic [ROOT_W-1:0]        qv [3];
	logic signed [DIR_W-1:0]  dnx [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
			cfg_q.eye    <= '0;
			cfg_q.corner <= '0;
			cfg_q.span_x <= '0;
			cfg_q.span_y <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data[DIM_W-1:0];
				REG_EYE:          cfg_q.eye    <= cfg_data;
				REG_CORNER:       cfg_q.corner <= cfg_data;
				REG_SPAN_X:       cfg_q.span_x <= cfg_data;
				REG_SPAN_Y:       cfg_q.span_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !out_vld_q || ray.ready;
	assign pix.ready = en;

	prg_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pix.valid),
		.pixel_row(pix.pixel_row), .pixel_col(pix.pixel_col), .cfg(cfg_q),
		.out_valid(fr_valid), .n2(fr_n2), .ssum(fr_ssum), .tag(fr_tag)
	);

	prg_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.n2(fr_n2), .ssum(fr_ssum), .in_tag(fr_tag),
		.out_valid(dv_valid), .quo(dv_quo), .out_tag(dv_tag)
	);

	prg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(dv_valid),
		.rad(dv_quo), .in_tag(dv_tag),
		.out_valid(sq_valid), .root(sq_root), .out_tag(sq_tag)
	);

	// largest odd value not above the root is 2q-1
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qv[k] = (sq_root[k] + 1'b1) >> 1;
			if (sq_tag.oor || sq_tag.szero)
				dnx[k] = '0;
			else if (sq_tag.neg[k])
				dnx[k] = DIR_W'(-qv[k]);
			else if (qv[k] > ROOT_W'(2**(DIR_W-1) - 1))
				dnx[k] = DIR_W'(2**(DIR_W-1) - 1);
			else
				dnx[k] = DIR_W'(qv[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q <= sq_tag.oor;
			for (int k = 0; k < 3; k++) begin
				org_q[k] <= sq_tag.oor ? '0 : comp_of(cfg_q.eye, k);
				dir_q[k] <= dnx[k];
			end
		end
	end

	assign ray.valid        = out_vld_q;
	assign ray.origin_x     = org_q[0];
	assign ray.origin_y     = org_q[1];
	assign ray.origin_z     = org_q[2];
	assign ray.dir_x        = dir_q[0];
	assign ray.dir_y        = dir_q[1];
	assign ray.dir_z        = dir_q[2];
	assign ray.out_of_range = oor_q;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.out_of_range |-> ray.dir_x == '0 && ray.dir_y == '0 &&
		ray.dir_z == '0 && ray.origin_x == '0 && ray.origin_y == '0 && ray.origin_z == '0)
		else $error("out-of-range word carries a nonzero ray");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && !sq_tag.szero && !sq_tag.oor |->
		!sq_root[0][ROOT_W-1] || sq_root[0][ROOT_W-2:0] == '0)
		else $error("square root above 2^16");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sq_valid) && $stable(dv_valid) && $stable(fr_valid))
		else $error("pipeline moved during stall");

endmodule
